FILE: hdl/mmf_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message framer package
// Shared codes, field widths and the status byte length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mmf_pkg;

   // Default sysex length limit (bytes counted from the opening F0)
   localparam int SYSEX_MAX_LEN_DEF = 256;

   // Channel widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   // Framer mode codes
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_SHORT = 2'd1;
   localparam logic [1:0] MODE_SYSEX = 2'd2;

   // Result event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_SYSEX = 2'd2;
   localparam logic [1:0] EV_ABORT = 2'd3;

   // Decoded length codes of a byte seen while idle
   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_SYSEX = 3'd4;

   // Marker bytes
   localparam logic [7:0] SYSEX_END = 8'hF7;
   localparam logic [7:0] SYSEX_START = 8'hF0;

   typedef struct packed {
      logic [1:0] event_res;
      logic [1:0] msg_length;
      logic [7:0] status_out;
      logic [7:0] data_first;
      logic [7:0] data_second;
      logic [7:0] sysex_byte;
      logic       sysex_first;
      logic       sysex_last;
   } rsp_type;

   // Message length chosen by a byte that arrives while idle
   function automatic logic [2:0] length_of(input logic [7:0] b);
      logic [2:0] len;
      len = LEN_NONE;
      case (b[7:4]) inside
         4'h5: begin
            len = LEN_ONE;
         end
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
            len = LEN_THREE;
         end
         4'hC, 4'hD: begin
            len = LEN_TWO;
         end
         4'hF: begin
            case (b[3:0]) inside
               4'h0:                    len = LEN_SYSEX;
               4'h1, 4'h3:              len = LEN_TWO;
               4'h2:                    len = LEN_THREE;
               [4'h6:4'hC], 4'hE, 4'hF: len = LEN_ONE;
               default:                 len = LEN_NONE;
            endcase
         end
         default: begin
            len = LEN_NONE;
         end
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/midi_message_framer.sv
// ----------------------------------------------------------------------------
// MIDI message framer
// Groups received MIDI bytes into short messages and streams sysex bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one MIDI byte per item on req_tdata[7:0].
//   rsp channel: exactly one result item per accepted byte. The event code
//     in rsp_tuser says what it is: nothing, a complete short message
//     (status plus up to two data bytes in rsp_tdata), one sysex byte, or a
//     sysex abort when the message grows to SYSEX_MAX_LEN bytes.
//     rsp_tlast marks the closing F7 of a sysex message.
//   Latency: the result of a byte is presented the cycle after it is
//     accepted; it is formed by the decode logic straight into the result
//     register, which is the only stage.
//   Throughput: one byte per cycle while the receiver keeps rsp_tready high.
//     A byte is taken while the previous result is handed over in the same
//     cycle, so the result register alone parts the two sides.
//   Stall: when the receiver holds rsp_tready low, the result holds and
//     req_tready drops until it is taken; no byte is lost.
//   Reset: the framer returns to idle, counters clear and no result is
//     pending. While idle, data bytes other than 5n, and F4, F5 and FD,
//     are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_message_framer
   import mmf_pkg::*;
#(
   parameter int SYSEX_MAX_LEN = SYSEX_MAX_LEN_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] midi_byte
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // [1:0] msg_length, [9:2] status_out,
                                                   // [17:10] data_first,
                                                   // [25:18] data_second,
                                                   // [33:26] sysex_byte, rest zero
   output      logic [RSP_USER_W-1:0] rsp_tuser,   // [1:0] event_res, [2] sysex_first
   output      logic                  rsp_tlast    // sysex_last
);

   localparam int CNT_W = $clog2(SYSEX_MAX_LEN + 1);

   // Framer state
   logic [1:0]       mode_ff, mode_in;
   logic [1:0]       exp_len_ff, exp_len_in;
   logic [1:0]       short_cnt_ff, short_cnt_in;
   logic [7:0]       held0_ff, held0_in;
   logic [7:0]       held1_ff, held1_in;
   logic [CNT_W-1:0] sysex_cnt_ff, sysex_cnt_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [7:0]       b;
   logic [2:0]       len;
   logic [2:0]       short_next;
   logic [CNT_W-1:0] sysex_inc;

   // Take a new byte whenever the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata[7:0];
   assign len        = length_of(b);
   assign short_next = {1'b0, short_cnt_ff} + 3'd1;
   assign sysex_inc  = sysex_cnt_ff + CNT_W'(1);

   always_comb begin
      mode_in      = mode_ff;
      exp_len_in   = exp_len_ff;
      short_cnt_in = short_cnt_ff;
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      sysex_cnt_in = sysex_cnt_ff;
      rsp_in       = '0;

      case (mode_ff)
         MODE_SHORT: begin
            if (short_next >= {1'b0, exp_len_ff}) begin
               // Last byte of the message: emit it whole and go idle
               rsp_in.event_res  = EV_SHORT;
               rsp_in.msg_length = exp_len_ff;
               rsp_in.status_out = held0_ff;
               if (exp_len_ff == 2'd2) begin
                  rsp_in.data_first = b;
               end else if (exp_len_ff == 2'd3) begin
                  rsp_in.data_first  = held1_ff;
                  rsp_in.data_second = b;
               end
               mode_in      = MODE_IDLE;
               exp_len_in   = 2'd0;
               short_cnt_in = 2'd0;
            end else begin
               // Hold the byte and advance
               if (short_cnt_ff[0]) begin
                  held1_in = b;
               end else begin
                  held0_in = b;
               end
               short_cnt_in = short_next[1:0];
            end
         end

         MODE_SYSEX: begin
            if (b == SYSEX_END) begin
               rsp_in.event_res  = EV_SYSEX;
               rsp_in.sysex_byte = b;
               rsp_in.sysex_last = 1'b1;
               mode_in           = MODE_IDLE;
               sysex_cnt_in      = '0;
            end else if (sysex_inc >= CNT_W'(SYSEX_MAX_LEN)) begin
               // Too long: drop the byte and abort the message
               rsp_in.event_res = EV_ABORT;
               mode_in          = MODE_IDLE;
               sysex_cnt_in     = '0;
            end else begin
               rsp_in.event_res  = EV_SYSEX;
               rsp_in.sysex_byte = b;
               sysex_cnt_in      = sysex_inc;
            end
         end

         default: begin
            // Idle, and the unused mode code behaves as idle
            mode_in      = MODE_IDLE;
            short_cnt_in = 2'd0;
            if (len == LEN_SYSEX) begin
               mode_in            = MODE_SYSEX;
               sysex_cnt_in       = CNT_W'(1);
               rsp_in.event_res   = EV_SYSEX;
               rsp_in.sysex_byte  = b;
               rsp_in.sysex_first = 1'b1;
            end else if (len == LEN_ONE) begin
               held0_in          = b;
               exp_len_in        = 2'd0;
               rsp_in.event_res  = EV_SHORT;
               rsp_in.msg_length = len[1:0];
               rsp_in.status_out = b;
            end else if (len != LEN_NONE) begin
               held0_in     = b;
               exp_len_in   = len[1:0];
               mode_in      = MODE_SHORT;
               short_cnt_in = 2'd1;
            end
         end
      endcase
   end

   // Result valid: set by an accepted byte, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         exp_len_ff   <= 2'd0;
         short_cnt_ff <= 2'd0;
         held0_ff     <= 8'd0;
         held1_ff     <= 8'd0;
         sysex_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff      <= mode_in;
            exp_len_ff   <= exp_len_in;
            short_cnt_ff <= short_cnt_in;
            held0_ff     <= held0_in;
            held1_ff     <= held1_in;
            sysex_cnt_ff <= sysex_cnt_in;
         end
      end
   end

   // Result payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.sysex_byte, rsp_ff.data_second, rsp_ff.data_first,
                        rsp_ff.status_out, rsp_ff.msg_length};
   assign rsp_tuser  = {rsp_ff.sysex_first, rsp_ff.event_res};
   assign rsp_tlast  = rsp_ff.sysex_last;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // A completed short message always carries at least its status byte
   a_short_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.event_res == EV_SHORT) |-> (rsp_ff.msg_length != 2'd0))
      else $error("short message with zero length");

   // The last mark goes only with the closing F7 of a sysex stream
   a_last_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_ff.event_res == EV_SYSEX && rsp_ff.sysex_byte == SYSEX_END))
      else $error("sysex last mark without closing byte");

   // The first mark goes only with the opening F0 and opens sysex mode
   a_first_start : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.sysex_first && $past(accept)) |->
         (rsp_ff.sysex_byte == SYSEX_START && mode_ff == MODE_SYSEX))
      else $error("sysex first mark without opening byte");

   // Inside sysex the count stays at least one and below the limit
   a_sysex_cnt : assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_SYSEX) |->
         (sysex_cnt_ff != '0 && sysex_cnt_ff < CNT_W'(SYSEX_MAX_LEN)))
      else $error("sysex count out of range");

endmodule

`default_nettype wire

FILE: dv/midi_message_framer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI message framer testbench
// Drives MIDI byte streams into the framer and checks every result item
// against a cycle-free model of the framing rules. The stimulus covers
// directed corner bytes, sysex runs at the length limit, back pressure and
// random traffic. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module midi_message_framer_tb;
   import mmf_pkg::*;

   localparam int SYSEX_LIMIT  = SYSEX_MAX_LEN_DEF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 620;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLDOFF_LEN  = 60;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // Framer state as the testbench sees it
   logic [1:0] fr_mode        = MODE_IDLE;
   logic [1:0] fr_len         = 2'd0;
   logic [1:0] fr_count       = 2'd0;
   logic [7:0] fr_held [2]    = '{8'h00, 8'h00};
   int         fr_sysex_count = 0;

   // Results still owed by the framer, oldest first
   rsp_type pending_results [$];

   int  mismatches   = 0;
   int  bytes_sent   = 0;
   int  bytes_framed = 0;
   int  short_msgs   = 0;
   int  sysex_bytes  = 0;
   int  aborts       = 0;
   int  cycle_count  = 0;
   int  holdoff_left = 0;
   bit  req_idle_on  = 1'b1;
   bit  rsp_idle_on  = 1'b1;

   midi_message_framer #(
      .SYSEX_MAX_LEN(SYSEX_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Framing model
   // ------------------------------------------------------------------------

   // Length class of a byte that arrives while the framer is idle
   function automatic logic [2:0] status_length(input logic [7:0] b);
      case (b[7:4])
         4'h5:                         return LEN_ONE;
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return LEN_THREE;
         4'hC, 4'hD:                   return LEN_TWO;
         4'hF: begin
            case (b[3:0])
               4'h0:             return LEN_SYSEX;
               4'h1, 4'h3:       return LEN_TWO;
               4'h2:             return LEN_THREE;
               4'h4, 4'h5, 4'hD: return LEN_NONE;
               default:          return LEN_ONE;
            endcase
         end
         default:                      return LEN_NONE;
      endcase
   endfunction

   // Emit the completed short message and go back to idle
   function automatic rsp_type close_short(input logic [7:0] last);
      rsp_type r;
      r            = '0;
      r.event_res  = EV_SHORT;
      r.msg_length = fr_len;
      r.status_out = fr_held[0];
      if ({1'b0, fr_len} == LEN_TWO) begin
         r.data_first = last;
      end else if ({1'b0, fr_len} == LEN_THREE) begin
         r.data_first  = fr_held[1];
         r.data_second = last;
      end
      fr_mode  = MODE_IDLE;
      fr_len   = 2'd0;
      fr_count = 2'd0;
      return r;
   endfunction

   // Advance the model by one accepted byte and return its result item
   function automatic rsp_type frame_byte(input logic [7:0] b);
      rsp_type    r;
      logic [2:0] len;
      r = '0;
      case (fr_mode)
         MODE_SHORT: begin
            // any byte, status bytes too, is taken as message content
            if (int'(fr_count) + 1 >= int'(fr_len)) begin
               r = close_short(b);
            end else begin
               fr_held[fr_count[0]] = b;
               fr_count             = fr_count + 2'd1;
            end
         end
         MODE_SYSEX: begin
            if (b == SYSEX_END) begin
               r.event_res    = EV_SYSEX;
               r.sysex_byte   = b;
               r.sysex_last   = 1'b1;
               fr_mode        = MODE_IDLE;
               fr_sysex_count = 0;
            end else begin
               fr_sysex_count++;
               if (fr_sysex_count >= SYSEX_LIMIT) begin
                  // drop the byte that hits the limit, report the abort
                  r.event_res    = EV_ABORT;
                  fr_mode        = MODE_IDLE;
                  fr_sysex_count = 0;
               end else begin
                  r.event_res  = EV_SYSEX;
                  r.sysex_byte = b;
               end
            end
         end
         default: begin
            // idle, and the unused mode code behaves the same
            len      = status_length(b);
            fr_mode  = MODE_IDLE;
            fr_count = 2'd0;
            if (len == LEN_SYSEX) begin
               fr_mode        = MODE_SYSEX;
               fr_sysex_count = 1;
               r.event_res    = EV_SYSEX;
               r.sysex_byte   = b;
               r.sysex_first  = 1'b1;
            end else if (len != LEN_NONE) begin
               fr_held[0] = b;
               fr_len     = len[1:0];
               if (len == LEN_ONE) begin
                  r = close_short(8'h00);
               end else begin
                  fr_mode  = MODE_SHORT;
                  fr_count = 2'd1;
               end
            end
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one byte, hold it until accepted, then record the expected result
   task automatic send_byte(input logic [7:0] b);
      bit framed;
      if (req_idle_on && $urandom_range(0, 99) < 7) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom_range(0, 255));
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      framed = (fr_mode != MODE_IDLE) || (status_length(b) != LEN_NONE);
      pending_results.push_back(frame_byte(b));
      bytes_sent++;
      if (framed) bytes_framed++;
   endtask

   // Drop valid and hold until every owed result has been taken
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_status();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (status_length(b) == LEN_NONE || status_length(b) == LEN_SYSEX);
      return b;
   endfunction

   // Mostly in-range data, now and then a status byte inside the message
   function automatic logic [7:0] random_data();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   // Sysex payload: data, real-time bytes and stray status, never the end mark
   function automatic logic [7:0] sysex_payload();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0:       b = 8'($urandom_range(8'hF8, 8'hFF));
         1:       b = 8'($urandom_range(0, 255));
         default: b = 8'($urandom_range(0, 127));
      endcase
      if (b == SYSEX_END) b = 8'hF8;
      return b;
   endfunction

   task automatic send_random_message();
      int         pick;
      int         n;
      logic [7:0] status;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         status = random_status();
         n      = int'(status_length(status)) - 1;
         // cut a few short so the next status gets swallowed as data
         if (n > 0 && $urandom_range(0, 19) == 0) n--;
         send_byte(status);
         repeat (n) send_byte(random_data());
      end else if (pick < 82) begin
         n = ($urandom_range(0, 99) < 3) ? $urandom_range(200, 300) : $urandom_range(0, 12);
         send_byte(SYSEX_START);
         repeat (n) send_byte(sysex_payload());
         // leave some unterminated so the run merges into what follows
         if ($urandom_range(0, 19) != 0) send_byte(SYSEX_END);
      end else begin
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Stall at random; a hold-off request keeps ready low for a counted stretch
   initial begin
      forever begin
         @(negedge clock);
         if (holdoff_left > 0) begin
            rsp_tready <= 1'b0;
            holdoff_left--;
         end else if (rsp_idle_on && $urandom_range(0, 99) < 7) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void report(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", what);
   endfunction

   function automatic string show(input rsp_type r);
      return $sformatf("ev=%0d len=%0d st=%02h d1=%02h d2=%02h sx=%02h first=%0b last=%0b",
                       r.event_res, r.msg_length, r.status_out, r.data_first,
                       r.data_second, r.sysex_byte, r.sysex_first, r.sysex_last);
   endfunction

   // Compare each taken result with the oldest expectation, field by field
   always @(posedge clock) begin : check_rsp
      rsp_type seen;
      rsp_type want;
      string   diffs;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.event_res   = rsp_tuser[1:0];
         seen.sysex_first = rsp_tuser[2];
         seen.sysex_last  = rsp_tlast;
         seen.msg_length  = rsp_tdata[1:0];
         seen.status_out  = rsp_tdata[9:2];
         seen.data_first  = rsp_tdata[17:10];
         seen.data_second = rsp_tdata[25:18];
         seen.sysex_byte  = rsp_tdata[33:26];
         if (pending_results.size() == 0) begin
            report($sformatf("[%0d] result with nothing expected: %s", cycle_count, show(seen)));
         end else begin
            want  = pending_results.pop_front();
            diffs = "";
            if (seen.event_res   !== want.event_res)   diffs = {diffs, " event_res"};
            if (seen.msg_length  !== want.msg_length)  diffs = {diffs, " msg_length"};
            if (seen.status_out  !== want.status_out)  diffs = {diffs, " status_out"};
            if (seen.data_first  !== want.data_first)  diffs = {diffs, " data_first"};
            if (seen.data_second !== want.data_second) diffs = {diffs, " data_second"};
            if (seen.sysex_byte  !== want.sysex_byte)  diffs = {diffs, " sysex_byte"};
            if (seen.sysex_first !== want.sysex_first) diffs = {diffs, " sysex_first"};
            if (seen.sysex_last  !== want.sysex_last)  diffs = {diffs, " sysex_last"};
            if (rsp_tdata[RSP_DATA_W-1:34] !== '0)     diffs = {diffs, " padding"};
            if (diffs != "") begin
               report($sformatf("[%0d] bad field(s)%s\n   expected %s\n   actual   %s",
                                cycle_count, diffs, show(want), show(seen)));
            end
            case (want.event_res)
               EV_SHORT: short_msgs++;
               EV_SYSEX: sysex_bytes++;
               EV_ABORT: aborts++;
               default: ;
            endcase
         end
      end
   end

   // Cycle counter: end a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout at cycle %0d with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Corner bytes: ignored codes, one-byte messages including the 5n fix,
   // data extremes, status bytes as data, all length classes, short sysex
   task automatic test_directed();
      logic [7:0] seq [$];
      seq = '{8'h00, 8'h7F, 8'hF4, 8'hF5, 8'hFD, 8'hF7,
              8'h50, 8'h5F, 8'hFF, 8'hF6,
              8'h80, 8'h00, 8'h7F,
              8'h9F, 8'hFF, 8'h80,
              8'hCF, 8'h7F,
              8'hF2, 8'h00, 8'h7F,
              8'hF0, 8'hF8, 8'hFF, 8'hF7,
              8'hF0, 8'hF7};
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // Longest sysex that still closes, then one that hits the limit
   task automatic test_sysex_limit();
      send_byte(SYSEX_START);
      repeat (SYSEX_LIMIT - 2) send_byte(sysex_payload());
      send_byte(SYSEX_END);
      send_byte(SYSEX_START);
      repeat (SYSEX_LIMIT - 1) send_byte(sysex_payload());
      // after the abort both bytes fall on an idle framer
      send_byte(8'h7F);
      send_byte(SYSEX_END);
      send_byte(8'hB3);
      send_byte(8'h40);
      send_byte(8'h7F);
   endtask

   // Hold the receiver off while bytes keep coming, then drain and resume
   task automatic test_backpressure();
      holdoff_left = HOLDOFF_LEN;
      repeat (12) send_random_message();
      wait_for_results();
      repeat (4) @(posedge clock);
      repeat (12) send_random_message();
   endtask

   // Random traffic with one stretch free of idling on both sides
   task automatic test_random();
      int start;
      bit quiet;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         quiet       = (bytes_sent - start >= 200) && (bytes_sent - start < 400);
         req_idle_on = !quiet;
         rsp_idle_on = !quiet;
         send_random_message();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_sysex_limit();
      test_backpressure();
      test_random();
      wait_for_results();
      // one register stage: waiting on after the drain catches any stray result
      repeat (4) @(posedge clock);
      $display("Sent %0d bytes, %0d of them framed, in %0d cycles",
               bytes_sent, bytes_framed, cycle_count);
      $display("Checked %0d short messages, %0d sysex bytes and %0d sysex aborts",
               short_msgs, sysex_bytes, aborts);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: midi_message_framer.f
hdl/mmf_pkg.sv
hdl/midi_message_framer.sv
dv/midi_message_framer_tb.sv
